### src/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  localparam logic [7:0]  HdrA          = 8'h7E;
  localparam logic [7:0]  HdrB          = 8'hE7;
  localparam logic [7:0]  TermByte      = 8'h0D;
  localparam logic [15:0] LinkHoldReset = 16'd500;
  localparam logic [7:0]  TimeoutReset  = 8'd100;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_DROP    = 3'd3,
    EV_BUSY    = 3'd4,
    EV_TIMEOUT = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_HDR2   = 4'd1,
    PH_HDR3   = 4'd2,
    PH_DST_HI = 4'd3,
    PH_DST_LO = 4'd4,
    PH_SRC_HI = 4'd5,
    PH_SRC_LO = 4'd6,
    PH_CMD    = 4'd7,
    PH_LEN    = 4'd8,
    PH_DATA   = 4'd9,
    PH_XOR    = 4'd10,
    PH_SUM    = 4'd11,
    PH_TERM   = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    CFG_ADDRESS_MODE = 2'd0,
    CFG_OWN_ADDRESS  = 2'd1,
    CFG_BYTE_TIMEOUT = 2'd2,
    CFG_LINK_HOLD    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic        valid;
    cfg_reg_e    index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic [7:0] cmd;
    logic [7:0] len;
    logic       link;
  } result_t;

endpackage

`default_nettype wire

### src/fcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_op_i,
  input  logic [7:0]         in_byte_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output fcr_pkg::item_t     item_o
);
  import fcr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  kind_e kind;

  // op decode
  always_comb begin
    unique case (in_op_i)
      2'd0:    kind = KIND_BYTE;
      2'd1:    kind = KIND_TICK;
      2'd2:    kind = KIND_RELEASE;
      default: kind = KIND_NOP;
    endcase
  end

  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_valid_i && in_ready_o) begin
      valid_d     = 1'b1;
      item_d.kind = kind;
      // only bytes carry data; keep it zero otherwise
      item_d.data = (kind == KIND_BYTE) ? in_byte_i : 8'h00;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

### src/fcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fcr_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fcr_pkg::item_t pop_item_o
);
  import fcr_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] r;
    if (p == QueuePtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + QueuePtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### src/fcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcr_pkg::cfg_wr_t  cfg_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  fcr_pkg::item_t    item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output fcr_pkg::result_t  res_o
);
  import fcr_pkg::*;

  // configuration
  logic        mode_q;
  logic [15:0] own_q;
  logic [7:0]  timeout_q;
  logic [15:0] hold_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] dst_q, dst_d;
  logic [15:0] src_q, src_d;
  logic        pending_q, pending_d;
  logic [7:0]  idle_q, idle_d;
  logic [15:0] link_ticks_q, link_ticks_d;
  logic        link_q, link_d;

  // result register
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        take, is_byte, tick_expire, addr_ok;
  logic [7:0]  b;
  event_e      ev;
  logic [7:0]  pb, pi;

  assign item_ready_o = !out_valid_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign b            = item_i.data;
  assign is_byte      = take && (item_i.kind == KIND_BYTE) && !pending_q;
  assign tick_expire  = !(idle_q < timeout_q);
  assign addr_ok      = !mode_q || ((dst_q == own_q) && (src_q == 16'h0000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      own_q     <= 16'h0000;
      timeout_q <= TimeoutReset;
      hold_q    <= LinkHoldReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ADDRESS_MODE: mode_q    <= cfg_i.data[0];
        CFG_OWN_ADDRESS:  own_q     <= cfg_i.data;
        CFG_BYTE_TIMEOUT: timeout_q <= cfg_i.data[7:0];
        CFG_LINK_HOLD:    hold_q    <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  // phase next state
  always_comb begin
    phase_d = phase_q;
    if (is_byte) begin
      unique case (phase_q)
        PH_HUNT:   phase_d = (b == HdrA) ? PH_HDR2 : PH_HUNT;
        PH_HDR2:   phase_d = (b == HdrB) ? PH_HDR3 : ((b == HdrA) ? PH_HDR2 : PH_HUNT);
        PH_HDR3:   phase_d = (b != HdrA) ? PH_HUNT : (mode_q ? PH_DST_HI : PH_CMD);
        PH_DST_HI: phase_d = PH_DST_LO;
        PH_DST_LO: phase_d = PH_SRC_HI;
        PH_SRC_HI: phase_d = PH_SRC_LO;
        PH_SRC_LO: phase_d = PH_CMD;
        PH_CMD:    phase_d = PH_LEN;
        PH_LEN:    phase_d = (b != 8'h00) ? PH_DATA : PH_XOR;
        PH_DATA:   phase_d = ((remain_q - 8'd1) == 8'h00) ? PH_XOR : PH_DATA;
        PH_XOR:    phase_d = (b == xor_q) ? PH_SUM : PH_HUNT;
        PH_SUM:    phase_d = (b == sum_q) ? PH_TERM : PH_HUNT;
        PH_TERM:   phase_d = PH_HUNT;
        default:   phase_d = PH_HUNT;
      endcase
    end else if (take && (item_i.kind == KIND_TICK) && tick_expire) begin
      phase_d = PH_HUNT;
    end
  end

  // datapath and event
  always_comb begin
    sum_d        = sum_q;
    xor_d        = xor_q;
    remain_d     = remain_q;
    pos_d        = pos_q;
    cmd_d        = cmd_q;
    len_d        = len_q;
    dst_d        = dst_q;
    src_d        = src_q;
    pending_d    = pending_q;
    idle_d       = idle_q;
    link_ticks_d = link_ticks_q;
    link_d       = link_q;
    ev           = EV_NONE;
    pb           = 8'h00;
    pi           = 8'h00;
    if (take) begin
      unique case (item_i.kind)
        KIND_BYTE: begin
          if (pending_q) begin
            ev = EV_BUSY;
          end else begin
            idle_d = 8'h00;
            unique case (phase_q)
              PH_HUNT: begin
                pos_d = 8'h00;
                sum_d = 8'h00;
                xor_d = 8'h00;
              end
              PH_DST_HI: dst_d[15:8] = b;
              PH_DST_LO: dst_d[7:0]  = b;
              PH_SRC_HI: src_d[15:8] = b;
              PH_SRC_LO: src_d[7:0]  = b;
              PH_CMD:    cmd_d       = b;
              PH_LEN: begin
                len_d    = b;
                remain_d = b;
              end
              PH_DATA: begin
                ev       = EV_PAYLOAD;
                pb       = b;
                pi       = pos_q;
                pos_d    = pos_q + 8'd1;
                remain_d = remain_q - 8'd1;
              end
              PH_XOR: ev = (b == xor_q) ? EV_NONE : EV_DROP;
              PH_SUM: ev = (b == sum_q) ? EV_NONE : EV_DROP;
              PH_TERM: begin
                if ((b == TermByte) && addr_ok) begin
                  pending_d    = 1'b1;
                  link_d       = 1'b1;
                  link_ticks_d = hold_q;
                  ev           = EV_ACCEPT;
                end else begin
                  ev = EV_DROP;
                end
              end
              default: ;
            endcase
            // running checks cover addresses through payload
            if ((phase_q == PH_DST_HI) || (phase_q == PH_DST_LO) ||
                (phase_q == PH_SRC_HI) || (phase_q == PH_SRC_LO) ||
                (phase_q == PH_CMD) || (phase_q == PH_LEN) || (phase_q == PH_DATA)) begin
              sum_d = sum_q + b;
              xor_d = xor_q ^ b;
            end
          end
        end
        KIND_TICK: begin
          if (!tick_expire) begin
            idle_d = idle_q + 8'd1;
          end else begin
            idle_d = 8'h00;
            if (phase_q != PH_HUNT) begin
              ev = EV_TIMEOUT;
            end
          end
          if (link_ticks_q != 16'h0000) begin
            link_ticks_d = link_ticks_q - 16'd1;
          end else begin
            link_d = 1'b0;
          end
        end
        KIND_RELEASE: pending_d = 1'b0;
        default:      ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_d.ev    = ev;
      out_d.pbyte = pb;
      out_d.pidx  = pi;
      out_d.cmd   = cmd_d;
      out_d.len   = len_d;
      out_d.link  = link_d;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      sum_q        <= 8'h00;
      xor_q        <= 8'h00;
      remain_q     <= 8'h00;
      pos_q        <= 8'h00;
      cmd_q        <= 8'h00;
      len_q        <= 8'h00;
      dst_q        <= 16'h0000;
      src_q        <= 16'h0000;
      pending_q    <= 1'b0;
      idle_q       <= 8'h00;
      link_ticks_q <= LinkHoldReset;
      link_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      sum_q        <= sum_d;
      xor_q        <= xor_d;
      remain_q     <= remain_d;
      pos_q        <= pos_d;
      cmd_q        <= cmd_d;
      len_q        <= len_d;
      dst_q        <= dst_d;
      src_q        <= src_d;
      pending_q    <= pending_d;
      idle_q       <= idle_d;
      link_ticks_q <= link_ticks_d;
      link_q       <= link_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

### src/framed_command_receiver.sv
// path: an accepted input beat passes the front register, then the queue, then
// the parser's result register before it appears as a result beat
// throughput: one input beat and one result beat per cycle, sustained while
// m_axis_tready stays high; every input beat yields exactly one result beat
// reset: rst_ni is asynchronous and active low; parser goes to header hunt,
// registers take their defaults (timeout 100, link hold 500), the queue empties
`timescale 1ns / 1ps
`default_nettype none

module framed_command_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                      // [23:16] command_code, [31:24] frame_length,
                                      // [32] link_alive, [39:33] zero
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);
  import fcr_pkg::*;

  cfg_wr_t cfg_wr;
  item_t   front_item, queue_item;
  logic    front_valid, front_ready;
  logic    queue_valid, queue_ready;
  result_t res;

  // registers are always writable; write them only while idle (the block does not enforce it)
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  // front: takes beats and decodes the op
  fcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  // short queue decoupling front and parser
  fcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  // back: frame parser, checks, timers and the result register
  fcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .item_i       (queue_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // pack result fields, highest field first (payload byte in the lowest bits)
  assign m_axis_tdata = {7'b0, res.link, res.len, res.cmd, res.pidx, res.pbyte};
  assign m_axis_tuser = res.ev;

endmodule

`default_nettype wire

### src/fcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_tvalid_i,
  input wire        m_tready_i,
  input wire [39:0] m_tdata_i,
  input wire [2:0]  m_tuser_i
);
  import fcr_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result beat changed while stalled");

  // payload fields are zero unless a payload event
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != EV_PAYLOAD) |-> (m_tdata_i[15:0] == 16'h0000))
    else $error("payload fields set on non-payload event");

  // an accepted frame brings the link alive
  a_accept_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == EV_ACCEPT) |-> m_tdata_i[32])
    else $error("accept without link alive");

  // two accepts can never be adjacent results
  a_no_double_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tready_i && (m_tuser_i == EV_ACCEPT)
      |=> !(m_tvalid_i && (m_tuser_i == EV_ACCEPT)))
    else $error("back-to-back frame accepts");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser)
);

`default_nettype wire
